// File: hdl/bbc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the block buffer cache
// no dependencies

package bbc_pkg;

    // request kinds
    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_PIN     = 2'd2;
    localparam logic [1:0] KIND_UNPIN   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOFREE = 2'd1;
    localparam logic [1:0] STATUS_UNDER  = 2'd2;
    localparam logic [1:0] STATUS_OVER   = 2'd3;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  dev;
        logic [31:0] block_number;
        logic [4:0]  entry_index;
        logic [31:0] now_tick;
    } bbc_req_t;

    // result beat
    typedef struct packed {
        logic [4:0] buffer_index;
        logic       hit;
        logic       needs_fill;
        logic [1:0] status;
    } bbc_rsp_t;

    // one buffer entry as stored in the entry ram
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [31:0] stamp;
        logic [7:0]  count;
        logic        cvalid;
    } bbc_entry_t;

    localparam int ENTRY_W = $bits(bbc_entry_t);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic single_rd;
        logic commit;
    } bbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_acquire;
        logic scan_last;
        logic out_free;
    } bbc_stat_t;

endpackage

// File: hdl/bbc_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/bbc_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the block buffer cache
// depends on bbc_pkg

module bbc_ctrl
    import bbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  bbc_stat_t stat,
    output bbc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SINGLE,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (stat.is_acquire)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && req_valid;
        cmd.single_rd = (state_reg == ST_SINGLE) && !stat.is_acquire;
        cmd.scan_rd   = (state_reg == ST_SCAN);
        cmd.commit    = (state_reg == ST_COMMIT) && stat.out_free;
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// File: hdl/bbc_dpath.sv
`timescale 1ns / 1ps
// datapath: entry ram, sweep trackers, update logic and result register
// depends on bbc_pkg, bbc_ram

module bbc_dpath
    import bbc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  bbc_req_t  req,
    input  bbc_cmd_t  cmd,
    output bbc_stat_t stat,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output bbc_rsp_t  rsp
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int IXW = (IW > 5) ? IW : 5;

    bbc_req_t         req_reg;
    logic [IW-1:0]    addr_reg;
    logic             rd_vld_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             found_vld_reg;
    logic [IW-1:0]    found_idx_reg;
    logic             victim_vld_reg;
    logic [IW-1:0]    victim_idx_reg;
    logic [31:0]      best_stamp_reg;
    bbc_entry_t       sel_reg;
    logic [ENTRIES-1:0] init_reg;
    logic             out_vld_reg;
    bbc_rsp_t         out_reg;

    logic [ENTRY_W-1:0] ram_q;
    bbc_entry_t       ent;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [IXW-1:0]   req_idx_ext;
    logic             in_range;
    logic             is_acq;
    logic             hit_match;
    logic             victim_better;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    bbc_entry_t       wr_data;
    bbc_rsp_t         res;
    logic [IXW-1:0]   found_ext;
    logic [IXW-1:0]   victim_ext;

    assign is_acq      = (req_reg.kind == KIND_ACQUIRE);
    assign req_idx_ext = IXW'(req_reg.entry_index);
    assign in_range    = (32'(req_reg.entry_index) < ENTRIES);
    assign found_ext   = IXW'(found_idx_reg);
    assign victim_ext  = IXW'(victim_idx_reg);

    // read address: sweep counter or the addressed entry
    assign rd_en   = cmd.scan_rd || cmd.single_rd;
    assign rd_addr = cmd.scan_rd ? addr_reg :
                     (in_range ? req_idx_ext[IW-1:0] : '0);

    bbc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_entry_ram (
        .clk  (clk),
        .we   (wr_en && cmd.commit),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    // entries never written read as all zero
    assign ent = init_reg[rd_idx_reg] ? bbc_entry_t'(ram_q) : '0;

    // per-entry comparisons on the beat coming out of the ram
    assign hit_match     = (ent.dev == req_reg.dev) && (ent.blk == req_reg.block_number);
    assign victim_better = (ent.count == 8'd0) &&
                           (!victim_vld_reg || (ent.stamp < best_stamp_reg));

    // update and result for the request
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = found_idx_reg;
        wr_data = sel_reg;
        res     = '0;
        res.buffer_index = req_reg.entry_index;
        res.status       = STATUS_OK;
        if (is_acq)
        begin
            if (found_vld_reg)
            begin
                res.buffer_index = found_ext[4:0];
                res.hit          = 1'b1;
                if (sel_reg.count == COUNT_MAX)
                begin
                    res.status = STATUS_OVER;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data.count  = sel_reg.count + 8'd1;
                    wr_data.cvalid = 1'b1;
                    res.needs_fill = !sel_reg.cvalid;
                end
            end
            else if (victim_vld_reg)
            begin
                wr_en            = 1'b1;
                wr_addr          = victim_idx_reg;
                wr_data.dev      = req_reg.dev;
                wr_data.blk      = req_reg.block_number;
                wr_data.stamp    = best_stamp_reg;
                wr_data.count    = 8'd1;
                wr_data.cvalid   = 1'b1;
                res.buffer_index = victim_ext[4:0];
                res.needs_fill   = 1'b1;
            end
            else
            begin
                res.buffer_index = '0;
                res.status       = STATUS_NOFREE;
            end
        end
        else if (in_range)
        begin
            wr_addr = req_idx_ext[IW-1:0];
            if (req_reg.kind == KIND_PIN)
            begin
                if (sel_reg.count == COUNT_MAX)
                begin
                    res.status = STATUS_OVER;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_data.count = sel_reg.count + 8'd1;
                end
            end
            else if (sel_reg.count == 8'd0)
            begin
                res.status = STATUS_UNDER;
            end
            else
            begin
                wr_en         = 1'b1;
                wr_data.count = sel_reg.count - 8'd1;
                if ((req_reg.kind == KIND_RELEASE) && (sel_reg.count == 8'd1))
                begin
                    wr_data.stamp = req_reg.now_tick;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg     <= 1'b0;
            found_vld_reg  <= 1'b0;
            victim_vld_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
            init_reg       <= '0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (cmd.load)
            begin
                found_vld_reg  <= 1'b0;
                victim_vld_reg <= 1'b0;
            end
            else if (rd_vld_reg && is_acq)
            begin
                if (hit_match)
                begin
                    found_vld_reg <= 1'b1;
                end
                if (victim_better)
                begin
                    victim_vld_reg <= 1'b1;
                end
            end
            if (cmd.commit && wr_en)
            begin
                init_reg[wr_addr] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req;
            addr_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            addr_reg <= addr_reg + IW'(1);
        end
        rd_idx_reg <= rd_addr;
        if (rd_vld_reg)
        begin
            if (!is_acq)
            begin
                sel_reg <= ent;
            end
            else
            begin
                if (hit_match)
                begin
                    found_idx_reg <= rd_idx_reg;
                    sel_reg       <= ent;
                end
                if (victim_better)
                begin
                    victim_idx_reg <= rd_idx_reg;
                    best_stamp_reg <= ent.stamp;
                end
            end
        end
        if (cmd.commit)
        begin
            out_reg <= res;
        end
    end

    assign stat.is_acquire = is_acq;
    assign stat.scan_last  = (addr_reg == IW'(ENTRIES - 1));
    assign stat.out_free   = !out_vld_reg || !rsp_stall;

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

endmodule

// File: hdl/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// top level of the block buffer cache with least-recently-released replacement
// depends on bbc_pkg, bbc_ctrl, bbc_dpath

// The block holds ENTRIES buffer entries (device and block tag, valid flag,
// reference count, release stamp) in one entry ram and serves one request at
// a time. An acquire sweeps the ram one entry per cycle, tracking the highest
// matching entry and the unreferenced entry with the oldest stamp. Release,
// pin and unpin read only the addressed entry. Entries start out zero after
// reset through per-entry written bits, so there is no clearing pass. A new
// request can be accepted while the previous result is stalled.

module block_buffer_cache_lru
    import bbc_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  bbc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output bbc_rsp_t rsp
);

    bbc_cmd_t  cmd;
    bbc_stat_t stat;

    // sequencing
    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and update logic
    bbc_dpath #(
        .ENTRIES(ENTRIES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule
